FILE: rtl/origin_outside_hull_2d_test_unit_macros.svh
// assertion macros for the origin-outside-hull test unit
`ifndef ORIGIN_OUTSIDE_HULL_2D_TEST_UNIT_MACROS_SVH
`define ORIGIN_OUTSIDE_HULL_2D_TEST_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define OOH_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OOH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ooh_pkg.sv
// shared types and constants of the origin-outside-hull test unit
`default_nettype none

package ooh_pkg;

   localparam int COORD_WIDTH = 24;
   // exact cross or dot product of two coordinate pairs
   localparam int PROD_WIDTH  = 2 * COORD_WIDTH + 1;
   localparam int TOL_WIDTH   = 32;
   localparam int CMP_WIDTH   = (PROD_WIDTH > TOL_WIDTH + 1) ? PROD_WIDTH : TOL_WIDTH + 1;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [TOL_WIDTH-1:0] TOL_RESET     = TOL_WIDTH'(429);
   localparam logic                 REG_TOLERANCE = 1'b0;

   // two-entry queues: count holds 0..2
   localparam logic [1:0] QUEUE_FULL = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      point_type pt;
      logic      last;
   } in_item_type;

   // wedge edges kept as the points they were rotated from
   typedef struct packed {
      point_type low;
      point_type high;
   } wedge_type;

   typedef struct packed {
      point_type pt;
      logic      last;
      logic      pend;   // previous point was decided in the cycle this one moved up
      prod_type  lp_w;   // low edge . p
      prod_type  ld_w;   // low source point . p
      prod_type  hp_w;   // high edge . p
      prod_type  hd_w;   // high source point . p
      prod_type  pc;     // cross of previous point and p
      prod_type  pd;     // dot of previous point and p
   } prod_item_type;

   function automatic prod_type mul(coord_type a, coord_type b);
      return prod_type'(a) * prod_type'(b);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/origin_outside_hull_2d_test_unit.sv
// top level of the origin-outside-hull test unit
`default_nettype none

`include "origin_outside_hull_2d_test_unit_macros.svh"

// Decides, for a set of 2D points pushed one per transaction, whether some
// line through the origin has every point of the set on one side. Points are
// signed fixed point with 16 fraction bits; the transaction with
// req_last_point high closes the set and yields exactly one result
// (rsp_origin_outside = 1 when such a line exists, 0 when the hull encloses
// the origin); other transactions yield none. The tolerance register (byte
// address 0, reset 429, units of 2^-32) sets the cross product magnitude that
// counts as zero. Throughput is one point per clock cycle while the result
// queue has room; a last point passes the input queue and product register
// before its verdict is queued. The rate is set by the back-end decision loop,
// which compares the registered products against the tolerance and moves a
// wedge edge in the same cycle; the front end registers products against both
// the current wedge and the point being decided, so no bubble is needed. Both
// sides are two-entry queues, so a waiting result does not block input.

module origin_outside_hull_2d_test_unit import ooh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // point transactions
   input  logic              req_push,
   output logic              req_full,
   input  coord_type         req_point_x,
   input  coord_type         req_point_y,
   input  logic              req_last_point,
   // verdict transactions
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_origin_outside,
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [TOL_WIDTH-1:0] tol_ff, tol_in;
   logic                 tol_write;

   wedge_type     wedge;
   logic          back_fire;
   logic          prod_valid;
   prod_item_type prod_item;
   logic          result_push;

   // register port: zero wait states, byte offset bits ignored
   assign csr_pready = 1'b1;
   assign tol_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[CSR_AW-1] == REG_TOLERANCE);

   always_comb begin
      tol_in = tol_write ? csr_pwdata[TOL_WIDTH-1:0] : tol_ff;
      if (csr_paddr[CSR_AW-1] == REG_TOLERANCE) begin
         csr_prdata = CSR_DW'(tol_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   // front end: input queue and product register
   ooh_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_last_point (req_last_point),
      .wedge          (wedge),
      .back_fire      (back_fire),
      .prod_valid     (prod_valid),
      .prod_item      (prod_item)
   );

   // back end: wedge update, set verdict and result queue
   ooh_back u_back (
      .clock              (clock),
      .reset              (reset),
      .tolerance          (tol_ff),
      .prod_valid         (prod_valid),
      .prod_item          (prod_item),
      .back_fire          (back_fire),
      .wedge              (wedge),
      .result_push        (result_push),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_origin_outside (rsp_origin_outside)
   );

   // a register write lands in the tolerance register
   `OOH_ASSERT_NEXT(a_tol_write, tol_write, tol_ff == $past(csr_pwdata[TOL_WIDTH-1:0]), "tolerance write lost")

   // a verdict shows up only after a last point was decided
   `OOH_ASSERT_SAME(a_result_source, $fell(rsp_empty), $past(result_push), "verdict without last point")

   // the input queue fills only on an accepted transaction
   `OOH_ASSERT_SAME(a_full_source, $rose(req_full), $past(req_push), "input queue filled without push")

endmodule

`default_nettype wire

FILE: rtl/ooh_front.sv
// front end: input queue and registered dot and cross products
`default_nettype none

module ooh_front import ooh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  coord_type     req_point_x,
   input  coord_type     req_point_y,
   input  logic          req_last_point,
   input  wedge_type     wedge,
   input  logic          back_fire,
   output logic          prod_valid,
   output prod_item_type prod_item
);

   in_item_type   queue_ff [2];
   logic [1:0]    cnt_ff, cnt_in;
   logic          wr_ptr_ff, rd_ptr_ff;
   logic          pv_ff, pv_in;
   prod_item_type pitem_ff, pitem_in;

   logic          push_ok, head_valid, move;
   in_item_type   head;
   point_type     prev;

   always_comb begin
      push_ok    = req_push && !req_full;
      head       = queue_ff[rd_ptr_ff];
      head_valid = (cnt_ff != 2'd0);
      move       = head_valid && (!pv_ff || back_fire);

      unique case ({push_ok, move})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase

      if (move) begin
         pv_in = 1'b1;
      end else if (back_fire) begin
         pv_in = 1'b0;
      end else begin
         pv_in = pv_ff;
      end

      // previous point sits in the product register while it is decided
      prev           = pitem_ff.pt;
      pitem_in.pt    = head.pt;
      pitem_in.last  = head.last;
      pitem_in.pend  = pv_ff;
      pitem_in.lp_w  = mul(wedge.low.y, head.pt.x) - mul(wedge.low.x, head.pt.y);
      pitem_in.ld_w  = mul(wedge.low.x, head.pt.x) + mul(wedge.low.y, head.pt.y);
      pitem_in.hp_w  = mul(wedge.high.x, head.pt.y) - mul(wedge.high.y, head.pt.x);
      pitem_in.hd_w  = mul(wedge.high.x, head.pt.x) + mul(wedge.high.y, head.pt.y);
      pitem_in.pc    = mul(prev.x, head.pt.y) - mul(prev.y, head.pt.x);
      pitem_in.pd    = mul(prev.x, head.pt.x) + mul(prev.y, head.pt.y);
   end

   assign req_full   = (cnt_ff == QUEUE_FULL);
   assign prod_valid = pv_ff;
   assign prod_item  = pitem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         pv_ff     <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         pv_ff  <= pv_in;
         if (push_ok) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (move) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= '{pt: '{x: req_point_x, y: req_point_y},
                                  last: req_last_point};
      end
      if (move) begin
         pitem_ff <= pitem_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ooh_back.sv
// back end: wedge decision, set state and result queue
`default_nettype none

module ooh_back import ooh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [TOL_WIDTH-1:0] tolerance,
   input  logic                 prod_valid,
   input  prod_item_type        prod_item,
   output logic                 back_fire,
   output wedge_type            wedge,
   output logic                 result_push,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic                 rsp_origin_outside
);

   wedge_type  wedge_ff, wedge_in;
   logic       awaiting_ff, awaiting_in;
   logic       failed_ff, failed_in;
   logic       upd_low_ff, upd_high_ff;
   logic       rq_ff [2];
   logic [1:0] rq_cnt_ff, rq_cnt_in;
   logic       rq_wr_ff, rq_rd_ff;

   logic                        rq_full, rsp_take, use_pl, use_ph, evaluate, fail_now;
   logic                        upd_low, upd_high, verdict;
   prod_type                    lp, ld, hp, hd;
   logic signed [CMP_WIDTH-1:0] lp_c, hp_c, tol_pos, tol_neg;
   logic                        front_l, behind_l, fail_l, front_h, behind_h, fail_h;

   always_comb begin
      rq_full   = (rq_cnt_ff == QUEUE_FULL);
      rsp_take  = rsp_pop && !rsp_empty;
      back_fire = prod_valid && (!prod_item.last || !rq_full);
      result_push = back_fire && prod_item.last;

      // forward the previous point when it just became an edge
      use_pl = prod_item.pend && upd_low_ff;
      use_ph = prod_item.pend && upd_high_ff;
      lp = use_pl ? -prod_item.pc : prod_item.lp_w;
      ld = use_pl ? prod_item.pd  : prod_item.ld_w;
      hp = use_ph ? prod_item.pc  : prod_item.hp_w;
      hd = use_ph ? prod_item.pd  : prod_item.hd_w;

      lp_c    = CMP_WIDTH'(lp);
      hp_c    = CMP_WIDTH'(hp);
      tol_pos = $signed(CMP_WIDTH'(tolerance));
      tol_neg = -tol_pos;

      front_l  = lp_c > tol_pos;
      behind_l = lp_c < tol_neg;
      fail_l   = !front_l && !behind_l && (ld[PROD_WIDTH-1] || (ld == '0));
      front_h  = hp_c > tol_pos;
      behind_h = hp_c < tol_neg;
      fail_h   = !front_h && !behind_h && (hd[PROD_WIDTH-1] || (hd == '0));

      evaluate = !awaiting_ff && !failed_ff;
      fail_now = evaluate && (fail_l || fail_h || (behind_l && behind_h));
      upd_low  = awaiting_ff || (evaluate && !fail_now && behind_l);
      upd_high = awaiting_ff || (evaluate && !fail_now && behind_h);
      verdict  = !(failed_ff || fail_now);

      wedge_in = wedge_ff;
      if (upd_low) begin
         wedge_in.low = prod_item.pt;
      end
      if (upd_high) begin
         wedge_in.high = prod_item.pt;
      end

      if (prod_item.last) begin
         awaiting_in = 1'b1;
         failed_in   = 1'b0;
      end else begin
         awaiting_in = 1'b0;
         failed_in   = failed_ff || fail_now;
      end

      unique case ({result_push, rsp_take})
         2'b10:   rq_cnt_in = rq_cnt_ff + 2'd1;
         2'b01:   rq_cnt_in = rq_cnt_ff - 2'd1;
         default: rq_cnt_in = rq_cnt_ff;
      endcase
   end

   assign wedge              = wedge_ff;
   assign rsp_empty          = (rq_cnt_ff == 2'd0);
   assign rsp_origin_outside = rq_ff[rq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b1;
         failed_ff   <= 1'b0;
         upd_low_ff  <= 1'b0;
         upd_high_ff <= 1'b0;
         rq_cnt_ff   <= 2'd0;
         rq_wr_ff    <= 1'b0;
         rq_rd_ff    <= 1'b0;
      end else begin
         rq_cnt_ff <= rq_cnt_in;
         if (back_fire) begin
            awaiting_ff <= awaiting_in;
            failed_ff   <= failed_in;
            upd_low_ff  <= upd_low;
            upd_high_ff <= upd_high;
         end
         if (result_push) begin
            rq_wr_ff <= !rq_wr_ff;
         end
         if (rsp_take) begin
            rq_rd_ff <= !rq_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (back_fire) begin
         wedge_ff <= wedge_in;
      end
      if (result_push) begin
         rq_ff[rq_wr_ff] <= verdict;
      end
   end

endmodule

`default_nettype wire
